FILE: hdl/lcps_pkg.sv
package lcps_pkg;

	localparam int unsigned UnitWidth = 12;
	localparam int unsigned WaitWidth = 15;
	localparam logic [UnitWidth-1:0] UnitReset = 12'd50;

	typedef enum logic [1:0] {
		PH_MODE_CHECK = 2'd0,
		PH_MODE_WAIT  = 2'd1,
		PH_HOLD       = 2'd2,
		PH_SPEED_WAIT = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		EFF_WALK   = 2'd0,
		EFF_MIRROR = 2'd1,
		EFF_BAR    = 2'd2,
		EFF_FILL   = 2'd3
	} effect_t;

	// Number of steps in each effect.
	function automatic logic [4:0] steps_of(input logic [1:0] eff);
		logic [4:0] n;
		begin
			case (effect_t'(eff))
				EFF_WALK:   n = 5'd8;
				EFF_MIRROR: n = 5'd8;
				EFF_BAR:    n = 5'd9;
				EFF_FILL:   n = 5'd5;
				default:    n = 5'd8;
			endcase
			return n;
		end
	endfunction

	// LED pattern shown for one step of one effect.
	function automatic logic [7:0] pattern_of(input logic [1:0] eff, input logic [3:0] s);
		logic [8:0] one_hot;
		logic [8:0] mirror;
		logic [8:0] bar;
		logic [7:0] top;
		logic [7:0] p;
		begin
			one_hot = 9'd1 << s;
			mirror  = 9'd1 << (3'd7 - s[2:0]);
			bar     = one_hot - 9'd1;
			top     = ~(8'hFF >> s);
			p       = 8'h00;
			if (s <= 4'd8) begin
				case (effect_t'(eff))
					EFF_WALK:   p = (s < 4'd8) ? one_hot[7:0] : 8'h00;
					EFF_MIRROR: p = (s < 4'd8) ? (one_hot[7:0] | mirror[7:0]) : 8'h00;
					EFF_BAR:    p = bar[7:0];
					EFF_FILL:   p = (s <= 4'd4) ? (bar[7:0] | top) : 8'h00;
					default:    p = 8'h00;
				endcase
			end
			return p;
		end
	endfunction

endpackage

FILE: hdl/led_chaser_pattern_sequencer.sv
// LED chaser pattern sequencer for an eight-bit LED port.
// Every beat on the slave stream is one timer tick carrying the two button
// levels (active low). For every tick the block returns exactly one beat on
// the master stream with the LED levels, the active effect and the speed.
// The pattern is held for 1, 2, 4 or 8 units; one unit is cfg_wr_data ticks,
// written through the configuration port. The user must write it only while
// the stream is idle; the block itself does not enforce this.
// A tick taken lands in the input register; its result is then loaded into the
// output register, which drives m_axis_tdata, once it is free or being emptied.
// Throughput: one tick per clock cycle while the receiver is ready; the state
// update is a short compare-and-select path between the two registers.
// When the receiver stalls, the finished result waits in the output register
// while one more tick is held in the input register; s_axis_tready drops only
// once both are full, and no beat is lost or repeated.
// Reset (arst_n low) clears the LEDs, selects the first effect and the
// fastest speed, sets the unit to 50 ticks and empties both registers. The
// first tick after reset only samples the mode button.
module led_chaser_pattern_sequencer
	import lcps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [11:0] cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] mode_button_n, [1] speed_button_n, [7:2] zero
	input  logic [7:0]  s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] led_pattern, [9:8] effect_number, [11:10] speed_number, [15:12] zero
	output logic [15:0] m_axis_tdata
);

	logic [UnitWidth-1:0] unit_q;

	logic       in_valid_s1;
	logic [1:0] buttons_s1;

	logic        out_valid_q;
	logic [15:0] out_data_q;

	phase_t               phase_q, phase_d;
	logic [WaitWidth-1:0] wait_q, wait_d;
	logic [3:0]           step_q, step_d;
	logic [1:0]           eff_q, eff_d;
	logic [1:0]           spd_q, spd_d;
	logic [7:0]           led_q, led_d;

	logic advance;

	// A tick moves into the output register whenever that register is free
	// or is being emptied in this cycle.
	assign advance       = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= UnitReset;
		end else if (cfg_wr_en) begin
			unit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			buttons_s1 <= s_axis_tdata[1:0];
		end
	end

	// Control state of the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MODE_CHECK;
			wait_q  <= '0;
			step_q  <= '0;
			eff_q   <= '0;
			spd_q   <= '0;
			led_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			wait_q  <= wait_d;
			step_q  <= step_d;
			eff_q   <= eff_d;
			spd_q   <= spd_d;
			led_q   <= led_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {4'd0, spd_d, eff_d, led_d};
		end
	end

	// Next-state logic for one tick.
	always_comb begin
		logic              mode_pressed;
		logic              speed_pressed;
		logic [WaitWidth:0] wait_inc;
		logic [WaitWidth:0] unit_len;
		logic [WaitWidth:0] hold_len;
		logic              unit_done;
		logic              hold_done;
		logic              do_next;
		logic              do_start;
		logic              do_load;
		logic [4:0]        step_inc;

		mode_pressed  = !buttons_s1[0];
		speed_pressed = !buttons_s1[1];
		wait_inc      = {1'b0, wait_q} + 16'd1;
		unit_len      = {4'd0, unit_q};
		hold_len      = unit_len << spd_q;
		unit_done     = wait_inc >= unit_len;
		hold_done     = wait_inc >= hold_len;
		step_inc      = {1'b0, step_q} + 5'd1;

		do_next  = 1'b0;
		do_start = 1'b0;
		do_load  = 1'b0;

		phase_d = phase_q;
		wait_d  = wait_q;
		step_d  = step_q;
		eff_d   = eff_q;
		spd_d   = spd_q;
		led_d   = led_q;

		case (phase_q)
			PH_MODE_CHECK: begin
				do_start = 1'b1;
			end
			PH_MODE_WAIT: begin
				if (unit_done) begin
					eff_d   = eff_q + 2'd1;
					step_d  = '0;
					do_load = 1'b1;
				end else begin
					wait_d = wait_inc[WaitWidth-1:0];
				end
			end
			PH_HOLD: begin
				if (hold_done) begin
					if (speed_pressed) begin
						wait_d  = '0;
						phase_d = PH_SPEED_WAIT;
					end else begin
						do_next = 1'b1;
					end
				end else begin
					wait_d = wait_inc[WaitWidth-1:0];
				end
			end
			PH_SPEED_WAIT: begin
				if (unit_done) begin
					spd_d   = spd_q + 2'd1;
					do_next = 1'b1;
				end else begin
					wait_d = wait_inc[WaitWidth-1:0];
				end
			end
			default: begin
				do_start = 1'b1;
			end
		endcase

		// After the last step of an effect the mode button is checked again.
		if (do_next) begin
			if (step_inc >= steps_of(eff_q)) begin
				do_start = 1'b1;
			end else begin
				step_d  = step_inc[3:0];
				do_load = 1'b1;
			end
		end

		if (do_start) begin
			wait_d = '0;
			if (mode_pressed) begin
				phase_d = PH_MODE_WAIT;
			end else begin
				step_d  = '0;
				do_load = 1'b1;
			end
		end

		if (do_load) begin
			led_d   = pattern_of(eff_d, step_d);
			wait_d  = '0;
			phase_d = PH_HOLD;
		end
	end

	// A ready receiver never stalls the input side.
	a_no_stall_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output side was ready");

	// A tick that moves forward always leaves a result beat behind.
	a_result_after_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_axis_tvalid)
		else $error("result beat missing after a tick was processed");

	// Sequencer state only changes when a tick is processed.
	a_state_stable_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(phase_q) && $stable(led_q) && $stable(wait_q)
			&& $stable(step_q)))
		else $error("sequencer state changed without a tick");

	// The step index never runs past the longest effect.
	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= 4'd8)
		else $error("step index out of range");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

// Every beat on the slave stream is one timer tick with the two button levels.
// The block answers each tick with exactly one beat on the master stream.
// An in-bench model of the chaser follows the accepted ticks and queues the
// LED state that each one should produce. The beats that come back are
// matched in order against that queue.
module testbench;
	import lcps_pkg::*;

	// Generous bound on the run.
	localparam int unsigned CycleLimit = 100000;

	typedef struct packed {
		logic speed_n;
		logic mode_n;
	} tick_t;

	typedef struct packed {
		logic [1:0] speed;
		effect_t    effect;
		logic [7:0] leds;
	} led_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [11:0] cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// [0] mode_button_n, [1] speed_button_n, [7:2] zero
	logic [7:0]  s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [7:0] led_pattern, [9:8] effect_number, [11:10] speed_number, [15:12] zero
	logic [15:0] m_axis_tdata;

	tick_t      ticks_to_send[$];
	led_state_t led_states_due[$];
	tick_t      next_tick;
	tick_t      held_buttons = '{speed_n: 1'b1, mode_n: 1'b1};
	led_state_t want;
	bit         calm = 1'b0;
	int         fail_count = 0;
	int unsigned cycle_count = 0;

	// Model of the chaser, advanced once per accepted tick.
	logic [11:0] unit_ticks = UnitReset;
	phase_t      sim_phase = PH_MODE_CHECK;
	effect_t     sim_effect = EFF_WALK;
	logic [1:0]  sim_speed = 2'd0;
	logic [7:0]  sim_led = 8'h00;
	int unsigned sim_step = 0;
	int unsigned sim_wait = 0;

	// A short walk over the button levels with a unit of one tick, so that
	// speed presses land on the ends of holds at every speed and mode presses
	// land on the ends of effects. Bit 1 is speed_n and bit 0 is mode_n.
	logic [1:0] button_drill [24] = '{
		2'b11, 2'b01, 2'b11, 2'b01, 2'b01, 2'b11, 2'b01, 2'b11,
		2'b11, 2'b01, 2'b11, 2'b11, 2'b11, 2'b11, 2'b01, 2'b00,
		2'b10, 2'b10, 2'b00, 2'b11, 2'b10, 2'b11, 2'b00, 2'b01
	};

	led_chaser_pattern_sequencer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Load step s of the current effect and start its hold.
	task automatic show_step(input int unsigned s);
		sim_step = s;
		case (sim_effect)
			EFF_WALK: begin
				sim_led = 8'd1 << s;
			end
			EFF_MIRROR: begin
				// One bit walks up from bit 0 while its mirror walks down from bit 7.
				sim_led = (8'd1 << s) | (8'h80 >> s);
			end
			EFF_BAR: begin
				// Nine steps, from all off up to all on.
				sim_led = 8'((9'd1 << s) - 9'd1);
			end
			default: begin
				// Bars grow in from both ends and meet after four steps.
				sim_led = ((8'd1 << s) - 8'd1) | ~(8'hFF >> s);
			end
		endcase
		sim_wait = 0;
		sim_phase = PH_HOLD;
	endtask

	// Start of an effect: a pressed mode button first costs one unit of waiting.
	task automatic begin_effect(input bit mode_hit);
		sim_wait = 0;
		if (mode_hit) begin
			sim_phase = PH_MODE_WAIT;
		end else begin
			show_step(0);
		end
	endtask

	task automatic step_forward(input bit mode_hit);
		int unsigned last;
		case (sim_effect)
			EFF_BAR:  last = 9;
			EFF_FILL: last = 5;
			default:  last = 8;
		endcase
		if (sim_step + 1 >= last) begin
			begin_effect(mode_hit);
		end else begin
			show_step(sim_step + 1);
		end
	endtask

	// One timer tick. A wait ends on the tick on which its count would reach
	// its length, and whatever follows uses that same tick's button levels.
	// A unit of zero therefore ends every wait on the next tick.
	task automatic advance_chaser(input tick_t t);
		int unsigned unit;
		int unsigned hold;
		unit = 32'(unit_ticks);
		hold = unit << sim_speed;
		case (sim_phase)
			PH_MODE_CHECK: begin
				begin_effect(!t.mode_n);
			end
			PH_MODE_WAIT: begin
				if (sim_wait + 1 >= unit) begin
					sim_effect = effect_t'(sim_effect + 2'd1);
					show_step(0);
				end else begin
					sim_wait++;
				end
			end
			PH_HOLD: begin
				if (sim_wait + 1 >= hold) begin
					if (!t.speed_n) begin
						sim_wait = 0;
						sim_phase = PH_SPEED_WAIT;
					end else begin
						step_forward(!t.mode_n);
					end
				end else begin
					sim_wait++;
				end
			end
			default: begin
				if (sim_wait + 1 >= unit) begin
					sim_speed = sim_speed + 2'd1;
					step_forward(!t.mode_n);
				end else begin
					sim_wait++;
				end
			end
		endcase
	endtask

	// Tick source. A new beat is offered only once the previous one is taken,
	// and with a chance of one in four a free slot is left empty unless the calm flag is up.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (ticks_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
				next_tick = ticks_to_send.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {6'd0, next_tick.speed_n, next_tick.mode_n};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result side. Returned beats are checked before the tick taken at the same
	// edge is modeled, so that a stray beat is never matched to that tick.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (led_states_due.size() == 0) begin
					$error("result beat %h with no tick waiting for it", m_axis_tdata);
					fail_count++;
				end else begin
					want = led_states_due.pop_front();
					if (m_axis_tdata[7:0] !== want.leds) begin
						$error("led_pattern expected %h actual %h", want.leds, m_axis_tdata[7:0]);
						fail_count++;
					end
					if (m_axis_tdata[9:8] !== want.effect) begin
						$error("effect_number expected %0d actual %0d", want.effect,
							m_axis_tdata[9:8]);
						fail_count++;
					end
					if (m_axis_tdata[11:10] !== want.speed) begin
						$error("speed_number expected %0d actual %0d", want.speed,
							m_axis_tdata[11:10]);
						fail_count++;
					end
				end
			end
			if (cfg_wr_en) begin
				unit_ticks = cfg_wr_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				advance_chaser(tick_t'(s_axis_tdata[1:0]));
				led_states_due.push_back('{speed: sim_speed, effect: sim_effect, leds: sim_led});
			end
		end
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 25);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("FAIL led_chaser_pattern_sequencer");
			$finish;
		end
	end

	// Returns once every tick has been sent and every result beat has come
	// back. The state is sampled at the falling edge, after the rising edge
	// has settled.
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (ticks_to_send.size() != 0 || s_axis_tvalid || led_states_due.size() != 0);
	endtask

	// The unit length is only changed while the stream is drained. The chaser
	// itself may still be partway through a wait, and the new length then
	// applies to that wait at once.
	task automatic write_unit(input logic [11:0] ticks);
		wait_drained();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ticks;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Random button levels, held in runs. The mode button is pressed often
	// enough to move between effects, and the speed button to cycle speeds.
	task automatic queue_ticks(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 1) == 1) begin
				held_buttons.mode_n = ($urandom_range(0, 99) >= 30);
				held_buttons.speed_n = ($urandom_range(0, 99) >= 25);
			end
			ticks_to_send.push_back(held_buttons);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// The reset unit of 50 ticks. The first tick after reset samples only the
		// mode button, and a press there sends the chaser into a mode wait.
		ticks_to_send.push_back('{speed_n: 1'b1, mode_n: 1'b0});
		queue_ticks(59);

		// A unit of one tick with a fixed button sequence.
		write_unit(12'd1);
		foreach (button_drill[i]) begin
			ticks_to_send.push_back(tick_t'(button_drill[i]));
		end
		queue_ticks(100);

		// A unit of zero ends every wait on the tick after it starts.
		write_unit(12'd0);
		queue_ticks(110);

		write_unit(12'd2);
		queue_ticks(100);

		// A long stretch without idle cycles on either side.
		write_unit(12'd3);
		calm = 1'b1;
		queue_ticks(100);

		// The longest unit. The last write then cuts the pending long hold short.
		write_unit(12'd4095);
		calm = 1'b0;
		queue_ticks(40);

		write_unit(12'd5);
		queue_ticks(70);

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS led_chaser_pattern_sequencer");
		end else begin
			$display("FAIL led_chaser_pattern_sequencer");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/lcps_pkg.sv
hdl/led_chaser_pattern_sequencer.sv
verif/testbench.sv
